>>> sv/pfa_pkg.sv
// ----------------------------------------------------------------------------
// pfa_pkg
// types and constants shared by the page frame allocator
// ----------------------------------------------------------------------------
package pfa_pkg;

	localparam int PAGE_BYTES  = 4096;
	localparam int RAM_PAGES   = 4096;
	localparam int MAP_ENTRIES = 16;

	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
	localparam int PN_W       = $clog2(RAM_PAGES);      // link table index
	localparam int PE_W       = PN_W + 1;               // page number up to RAM_PAGES
	localparam int RI_W       = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
	localparam int RC_W       = $clog2(MAP_ENTRIES + 1);
	localparam int CFG_W      = 25;

	typedef enum logic [2:0] {
		ACT_ADD     = 3'd0,
		ACT_ALLOC   = 3'd1,
		ACT_FREE    = 3'd2,
		ACT_RELEASE = 3'd3,
		ACT_CLEAR   = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_REJECT   = 2'd1,
		ST_NO_PAGE  = 2'd2,
		ST_IGNORED  = 2'd3
	} status_t;

	localparam logic CFG_MEM_BYTES = 1'b0;
	localparam logic CFG_DMAP      = 1'b1;

	typedef struct packed {
		logic [2:0]  action;
		logic [63:0] address;
		logic [63:0] length;
		logic        region_usable;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] page_address;
		logic [63:0] free_pages;
	} rsp_t;

	typedef struct packed {
		logic        index;
		logic [63:0] data;
	} cfg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ADD,
		S_ALLOC,
		S_ALLOC_POP,
		S_SCAN,
		S_SCAN_CHK,
		S_BUMP,
		S_FREE,
		S_REL_CHK,
		S_REL_STEP,
		S_CLEAR,
		S_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic do_add;
		logic do_pop_rd;
		logic do_pop;
		logic scan_rd;
		logic scan_load;
		logic scan_fail;
		logic do_bump;
		logic do_free;
		logic rel_init;
		logic rel_step;
		logic do_clear;
		logic fail_alloc;
		logic respond;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [2:0] action;
		logic       list_nonempty;
		logic       head_bad;
		logic       bump_avail;
		logic       scan_more;
		logic       scan_hit;
		logic       rel_ok;
		logic       rel_last;
	} sts_t;

endpackage

>>> sv/page_frame_allocator_top.sv
// ----------------------------------------------------------------------------
// page_frame_allocator_top
// physical page allocator: region table with bump pointer plus lifo free list
// ----------------------------------------------------------------------------
// steps: add/free/clear/unknown act after capture, then respond; alloc from the
//   free list reads the head link, then pops; an alloc refused at the list
//   head responds directly; a bump alloc scans the region table for another
//   region if needed; release_range frees page by page (link memory write port)
// throughput: one transaction at a time, start taken while busy is low
// reset: arst_n clears control and allocator state; other registers, the
//   region table and link memory have no reset and are only read where written
// the receiver cannot stall: done is a one-cycle strobe
module page_frame_allocator_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  pfa_pkg::req_t req,
	output logic          done,
	output pfa_pkg::rsp_t rsp,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  pfa_pkg::cfg_t cfg
);
	import pfa_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// configuration is always taken
	assign cfg_ready = 1'b1;

	pfa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.sts    (sts)
	);

	pfa_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cfg_we (cfg_valid),
		.cfg    (cfg),
		.cmd    (cmd),
		.sts    (sts),
		.done   (done),
		.rsp    (rsp)
	);

endmodule

>>> sv/pfa_ctrl.sv
// ----------------------------------------------------------------------------
// pfa_ctrl
// sequencer for the page frame allocator
// ----------------------------------------------------------------------------
module pfa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	output pfa_pkg::cmd_t cmd,
	input  pfa_pkg::sts_t sts
);
	import pfa_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) state_d = S_ADD;
			end
			S_ADD: begin
				case (sts.action)
					ACT_ADD:     state_d = S_DONE;
					ACT_ALLOC:   state_d = S_ALLOC;
					ACT_FREE:    state_d = S_DONE;
					ACT_RELEASE: state_d = S_REL_CHK;
					ACT_CLEAR:   state_d = S_DONE;
					default:     state_d = S_DONE;
				endcase
			end
			S_ALLOC: begin
				if (sts.list_nonempty) state_d = sts.head_bad ? S_DONE : S_ALLOC_POP;
				else if (sts.bump_avail) state_d = S_BUMP;
				else state_d = S_SCAN;
			end
			S_ALLOC_POP: state_d = S_DONE;
			S_SCAN: state_d = sts.scan_more ? S_SCAN_CHK : S_DONE;
			S_SCAN_CHK: state_d = sts.scan_hit ? S_BUMP : S_SCAN;
			S_BUMP: state_d = S_DONE;
			S_REL_CHK: state_d = (sts.rel_ok && !sts.rel_last) ? S_REL_STEP : S_DONE;
			S_REL_STEP: state_d = sts.rel_last ? S_DONE : S_REL_STEP;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: cmd.capture = start;
			S_ADD: begin
				case (sts.action)
					ACT_ADD:     cmd.do_add = 1'b1;
					ACT_FREE:    cmd.do_free = 1'b1;
					ACT_RELEASE: cmd.rel_init = 1'b1;
					ACT_CLEAR:   cmd.do_clear = 1'b1;
					default:     cmd.do_add = 1'b0;
				endcase
			end
			S_ALLOC: begin
				if (sts.list_nonempty) begin
					if (sts.head_bad) cmd.fail_alloc = 1'b1;
					else cmd.do_pop_rd = 1'b1;
				end
			end
			S_ALLOC_POP: cmd.do_pop = 1'b1;
			S_SCAN: begin
				if (sts.scan_more) cmd.scan_rd = 1'b1;
				else begin
					cmd.scan_fail  = 1'b1;
					cmd.fail_alloc = 1'b1;
				end
			end
			S_SCAN_CHK: cmd.scan_load = sts.scan_hit;
			S_BUMP: cmd.do_bump = 1'b1;
			S_REL_STEP: cmd.rel_step = 1'b1;
			S_DONE: cmd.respond = 1'b1;
			default: cmd.respond = 1'b0;
		endcase
	end

endmodule

>>> sv/pfa_dp.sv
// ----------------------------------------------------------------------------
// pfa_dp
// allocator state, region table, link memory and result register
// ----------------------------------------------------------------------------
module pfa_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  pfa_pkg::req_t req,
	input  logic          cfg_we,
	input  pfa_pkg::cfg_t cfg,
	input  pfa_pkg::cmd_t cmd,
	output pfa_pkg::sts_t sts,
	output logic          done,
	output pfa_pkg::rsp_t rsp
);
	import pfa_pkg::*;

	logic [CFG_W-1:0] mem_bytes_q, dmap_q;
	req_t             req_q;
	logic [PE_W-1:0]  reg_first_q [MAP_ENTRIES];
	logic [PE_W-1:0]  reg_end_q   [MAP_ENTRIES];
	logic [RC_W-1:0]  reg_count_q, scan_q;
	logic [PE_W-1:0]  bump_next_q, bump_end_q;
	logic [PN_W-1:0]  head_q;
	logic [PN_W-1:0]  link_mem [RAM_PAGES];
	logic [PN_W-1:0]  link_rd_q;
	logic [63:0]      total_q;
	logic [1:0]       status_q;
	logic [63:0]      page_q;
	logic [PE_W-1:0]  sc_first_q, sc_end_q;
	logic [63:0]      rel_addr_q, rel_last_q;
	logic             done_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_bytes_q <= '0;
			dmap_q      <= '0;
		end else if (cfg_we) begin
			if (cfg.index == CFG_MEM_BYTES) mem_bytes_q <= cfg.data[CFG_W-1:0];
			else                            dmap_q      <= cfg.data[CFG_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) req_q <= req;
	end

	// add_region checks
	logic [64:0] end_sum;
	logic [63:0] endb, firstb_raw, firstb;
	logic        add_bad;
	logic [51:0] ep_full;
	logic [PE_W-1:0] ep, fp;
	logic [63:0] pages;
	logic [64:0] tot_sum;
	assign end_sum    = {1'b0, req_q.address} + {1'b0, req_q.length};
	assign endb       = {end_sum[63:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
	assign firstb_raw = req_q.address + 64'(PAGE_BYTES - 1);
	assign firstb     = ({firstb_raw[63:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}} == 64'd0) ?
	                    64'(PAGE_BYTES) : {firstb_raw[63:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
	assign ep_full    = endb[63:PAGE_SHIFT];
	assign ep         = ep_full[PE_W-1:0];
	assign fp         = (firstb[63:PAGE_SHIFT] > 52'(ep_full)) ? ep
	                    : firstb[PAGE_SHIFT+PE_W-1:PAGE_SHIFT];
	assign pages      = 64'(ep - fp);
	assign tot_sum    = {1'b0, total_q} + {1'b0, pages};
	assign add_bad    = (req_q.length == 64'd0) || end_sum[64] ||
	                    (req_q.address > ~64'(PAGE_BYTES - 1)) ||
	                    (endb > 64'(mem_bytes_q)) || (ep_full > 52'(RAM_PAGES)) ||
	                    (reg_count_q >= RC_W'(MAP_ENTRIES)) || tot_sum[64];

	// free page check, shared by free and release
	logic [63:0] fr_addr;
	logic        fr_bad;
	assign fr_addr = cmd.rel_step ? rel_addr_q : req_q.address;
	assign fr_bad  = (fr_addr == 64'd0) || (fr_addr[PAGE_SHIFT-1:0] != '0) ||
	                 (64'(mem_bytes_q) < 64'(PAGE_BYTES)) ||
	                 (fr_addr > 64'(mem_bytes_q) - 64'(PAGE_BYTES)) ||
	                 (fr_addr[63:PAGE_SHIFT] >= 52'(RAM_PAGES)) ||
	                 (fr_addr >= 64'(dmap_q));

	// release checks
	logic [64:0] rel_sum;
	assign rel_sum = {1'b0, req_q.address} + {1'b0, req_q.length};
	logic rel_ok;
	assign rel_ok = (req_q.address[PAGE_SHIFT-1:0] == '0) &&
	                (req_q.length[PAGE_SHIFT-1:0] == '0) && !rel_sum[64] &&
	                (rel_sum[63:0] <= 64'(mem_bytes_q));

	logic [63:0] head_addr, bump_addr;
	assign head_addr = 64'(head_q) << PAGE_SHIFT;
	assign bump_addr = 64'(bump_next_q) << PAGE_SHIFT;
	logic [RI_W-1:0] scan_idx;
	assign scan_idx = scan_q[RI_W-1:0];

	assign sts.action        = req_q.action;
	assign sts.list_nonempty = (head_q != '0);
	assign sts.head_bad      = head_addr >= 64'(dmap_q);
	assign sts.bump_avail    = bump_next_q < bump_end_q;
	assign sts.scan_more     = (scan_q < reg_count_q) && (scan_q < RC_W'(MAP_ENTRIES));
	assign sts.scan_hit      = sc_first_q < sc_end_q;
	assign sts.rel_ok        = rel_ok;
	assign sts.rel_last      = cmd.rel_step ? (rel_addr_q == rel_last_q)
	                                        : (req_q.length == 64'd0);

	// link memory
	always_ff @(posedge clk) begin
		if ((cmd.do_free && !fr_bad) || (cmd.rel_step && !fr_bad))
			link_mem[fr_addr[PAGE_SHIFT+PN_W-1:PAGE_SHIFT]] <= head_q;
		link_rd_q <= link_mem[head_q];
	end

	// region table
	always_ff @(posedge clk) begin
		if (cmd.do_add && req_q.region_usable && !add_bad) begin
			reg_first_q[reg_count_q[RI_W-1:0]] <= fp;
			reg_end_q[reg_count_q[RI_W-1:0]]   <= ep;
		end
		if (cmd.scan_rd) begin
			sc_first_q <= reg_first_q[scan_idx];
			sc_end_q   <= reg_end_q[scan_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rel_init) begin
			rel_addr_q <= req_q.address;
			rel_last_q <= rel_sum[63:0] - 64'(PAGE_BYTES);
		end else if (cmd.rel_step) begin
			rel_addr_q <= rel_addr_q + 64'(PAGE_BYTES);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_count_q <= '0;
			scan_q      <= '0;
			bump_next_q <= '0;
			bump_end_q  <= '0;
			head_q      <= '0;
			total_q     <= '0;
			status_q    <= ST_OK;
			page_q      <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= cmd.respond;
			if (cmd.capture) begin
				status_q <= ST_OK;
				page_q   <= '0;
			end
			if (cmd.do_add) begin
				if (!req_q.region_usable) status_q <= ST_OK;
				else if (add_bad) status_q <= ST_REJECT;
				else begin
					reg_count_q <= reg_count_q + 1'b1;
					total_q     <= tot_sum[63:0];
				end
			end
			if (cmd.do_pop) begin
				head_q  <= link_rd_q;
				total_q <= total_q - 64'd1;
				page_q  <= head_addr;
			end
			if (cmd.scan_rd) scan_q <= scan_q + 1'b1;
			if (cmd.scan_load) begin
				bump_next_q <= sc_first_q;
				bump_end_q  <= sc_end_q;
			end
			if (cmd.scan_fail) begin
				bump_next_q <= '0;
				bump_end_q  <= '0;
			end
			if (cmd.fail_alloc) status_q <= ST_NO_PAGE;
			if (cmd.do_bump) begin
				bump_next_q <= bump_next_q + 1'b1;
				if (bump_next_q == '0 || bump_addr >= 64'(dmap_q)) status_q <= ST_NO_PAGE;
				else begin
					total_q <= total_q - 64'd1;
					page_q  <= bump_addr;
				end
			end
			if ((cmd.do_free || cmd.rel_step) && !fr_bad) begin
				head_q  <= fr_addr[PAGE_SHIFT+PN_W-1:PAGE_SHIFT];
				total_q <= total_q + 64'd1;
			end
			if (cmd.do_free && fr_bad) status_q <= ST_IGNORED;
			if (cmd.rel_init && !rel_ok) status_q <= ST_IGNORED;
			if (cmd.do_clear) begin
				reg_count_q <= '0;
				scan_q      <= '0;
				bump_next_q <= '0;
				bump_end_q  <= '0;
				head_q      <= '0;
				total_q     <= '0;
			end
			if (cmd.respond && req_q.action > ACT_CLEAR) status_q <= ST_IGNORED;
		end
	end

	assign done             = done_q;
	assign rsp.status       = status_q;
	assign rsp.page_address = page_q;
	assign rsp.free_pages   = total_q;

endmodule

>>> sv/pfa_checker.sv
// ----------------------------------------------------------------------------
// pfa_checker
// port level checks on the page frame allocator
// ----------------------------------------------------------------------------
module pfa_port_props (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input pfa_pkg::rsp_t rsp
);
	import pfa_pkg::*;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("busy not raised");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result without transaction");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");
	a_page_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.page_address != 64'd0 |-> rsp.status == ST_OK)
		else $error("page given with failing status");

endmodule

bind page_frame_allocator_top pfa_port_props u_pfa_port_props (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);
